/* hdl/cwct_pkg.sv */
// Shared types, codes and constants for the clock with countdown timer.
`timescale 1ns / 1ps

package cwct_pkg;

    // Kind of input beat
    typedef enum logic [1:0] {
        MODE_CLK_TICK = 2'd0,
        MODE_TMR_TICK = 2'd1,
        MODE_BLINK    = 2'd2,
        MODE_KEY      = 2'd3
    } t_mode;

    // Operating phase
    typedef enum logic [2:0] {
        PH_SET_CLK_HR  = 3'd0,
        PH_SET_CLK_MIN = 3'd1,
        PH_SET_TMR_HR  = 3'd2,
        PH_SET_TMR_MIN = 3'd3,
        PH_CLOCK       = 3'd4,
        PH_TMR_RUN     = 3'd5,
        PH_ALARM       = 3'd6
    } t_phase;

    // Key codes
    localparam logic [3:0] KEY_UP     = 4'd4;
    localparam logic [3:0] KEY_SWITCH = 4'd8;
    localparam logic [3:0] KEY_DOWN   = 4'd12;

    // Configuration register indexes
    localparam logic [1:0] CFG_CLK_DIV   = 2'd0;
    localparam logic [1:0] CFG_TMR_DIV   = 2'd1;
    localparam logic [1:0] CFG_BLINK_DIV = 2'd2;

    localparam logic [5:0] HOUR_TOP   = 6'd23;
    localparam logic [5:0] MIN_TOP    = 6'd59;
    localparam logic [5:0] SEC_RELOAD = 6'd60;

    typedef struct packed {
        logic [15:0] clk_div;
        logic [15:0] tmr_div;
        logic [15:0] blink_div;
    } t_cfg;

    // State as seen by the display formatter
    typedef struct packed {
        t_phase      phase;
        logic [4:0]  clk_hr;
        logic [5:0]  clk_min;
        logic [4:0]  tmr_hr;
        logic [5:0]  tmr_min;
        logic        blink;
        logic        lamp;
    } t_view;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [2:0] phase_now;
        logic       alarm_on;
        logic       lamp_on;
        logic       minute_tens_blank;
        logic       hour_tens_blank;
        logic [3:0] minute_units;
        logic [2:0] minute_tens;
        logic [3:0] hour_units;
        logic [1:0] hour_tens;
    } t_result;

    function automatic logic [5:0] fn_wrap_up(input logic [5:0] v, input logic [5:0] top);
        fn_wrap_up = (v >= top) ? 6'd0 : 6'(v + 6'd1);
    endfunction

    function automatic logic [5:0] fn_wrap_down(input logic [5:0] v, input logic [5:0] top);
        fn_wrap_down = (v == 6'd0 || v > top) ? top : 6'(v - 6'd1);
    endfunction

endpackage

/* hdl/cwct_state.sv */
// State registers and next-state logic of the clock, timer and blink phase.
`timescale 1ns / 1ps

module cwct_state (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  cwct_pkg::t_mode i_mode,
    input  logic [3:0]     i_key,
    input  cwct_pkg::t_cfg i_cfg,
    output cwct_pkg::t_view o_view
);
    import cwct_pkg::*;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_clk_hr, n_clk_hr;
    logic [5:0]  r_clk_min, n_clk_min;
    logic [5:0]  r_clk_sec, n_clk_sec;
    logic [15:0] r_clk_pre, n_clk_pre;
    logic [4:0]  r_tmr_hr, n_tmr_hr;
    logic [5:0]  r_tmr_min, n_tmr_min;
    logic [5:0]  r_tmr_sec, n_tmr_sec;
    logic [15:0] r_tmr_pre, n_tmr_pre;
    logic [15:0] r_blink_pre, n_blink_pre;
    logic        r_blink, n_blink;
    logic        r_lamp, n_lamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SET_CLK_HR;
            r_clk_hr    <= '0;
            r_clk_min   <= '0;
            r_clk_sec   <= '0;
            r_clk_pre   <= '0;
            r_tmr_hr    <= '0;
            r_tmr_min   <= '0;
            r_tmr_sec   <= SEC_RELOAD;
            r_tmr_pre   <= '0;
            r_blink_pre <= '0;
            r_blink     <= 1'b0;
            r_lamp      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_clk_hr    <= n_clk_hr;
            r_clk_min   <= n_clk_min;
            r_clk_sec   <= n_clk_sec;
            r_clk_pre   <= n_clk_pre;
            r_tmr_hr    <= n_tmr_hr;
            r_tmr_min   <= n_tmr_min;
            r_tmr_sec   <= n_tmr_sec;
            r_tmr_pre   <= n_tmr_pre;
            r_blink_pre <= n_blink_pre;
            r_blink     <= n_blink;
            r_lamp      <= n_lamp;
        end
    end

    always_comb begin
        logic [15:0] clk_inc;
        logic [15:0] tmr_inc;
        logic [15:0] blink_inc;
        clk_inc     = 16'(r_clk_pre + 16'd1);
        tmr_inc     = 16'(r_tmr_pre + 16'd1);
        blink_inc   = 16'(r_blink_pre + 16'd1);
        n_phase     = r_phase;
        n_clk_hr    = r_clk_hr;
        n_clk_min   = r_clk_min;
        n_clk_sec   = r_clk_sec;
        n_clk_pre   = r_clk_pre;
        n_tmr_hr    = r_tmr_hr;
        n_tmr_min   = r_tmr_min;
        n_tmr_sec   = r_tmr_sec;
        n_tmr_pre   = r_tmr_pre;
        n_blink_pre = r_blink_pre;
        n_blink     = r_blink;
        n_lamp      = r_lamp;

        if (i_fire) begin
            case (i_mode)
                MODE_CLK_TICK: begin
                    // Clock stands still only while its own fields are being set.
                    if (r_phase[2] || r_phase[1]) begin
                        if (clk_inc >= i_cfg.clk_div) begin
                            n_clk_pre = '0;
                            if (r_clk_sec >= MIN_TOP) begin
                                n_clk_sec = '0;
                                if (r_clk_min >= MIN_TOP) begin
                                    n_clk_min = '0;
                                    n_clk_hr  = (r_clk_hr >= 5'(HOUR_TOP)) ? 5'd0
                                                                          : 5'(r_clk_hr + 5'd1);
                                end else begin
                                    n_clk_min = 6'(r_clk_min + 6'd1);
                                end
                            end else begin
                                n_clk_sec = 6'(r_clk_sec + 6'd1);
                            end
                        end else begin
                            n_clk_pre = clk_inc;
                        end
                    end
                end
                MODE_TMR_TICK: begin
                    if (r_phase == PH_TMR_RUN) begin
                        if (tmr_inc >= i_cfg.tmr_div) begin
                            n_tmr_pre = '0;
                            if (r_tmr_sec > 6'd1 && r_tmr_sec <= SEC_RELOAD) begin
                                n_tmr_sec = 6'(r_tmr_sec - 6'd1);
                            end else begin
                                n_tmr_sec = SEC_RELOAD;
                                if (r_tmr_min != 6'd0) begin
                                    n_tmr_min = 6'(r_tmr_min - 6'd1);
                                    if (r_tmr_min == 6'd1 && r_tmr_hr == 5'd0) begin
                                        n_phase = PH_ALARM;
                                    end
                                end else if (r_tmr_hr != 5'd0) begin
                                    n_tmr_min = MIN_TOP;
                                    n_tmr_hr  = 5'(r_tmr_hr - 5'd1);
                                end else begin
                                    n_phase = PH_ALARM;
                                end
                            end
                        end else begin
                            n_tmr_pre = tmr_inc;
                        end
                    end
                end
                MODE_BLINK: begin
                    if (!r_phase[2]) begin
                        if (blink_inc >= i_cfg.blink_div) begin
                            n_blink_pre = '0;
                            n_blink     = !r_blink;
                            if (r_phase[1]) begin
                                n_lamp = !r_lamp;
                            end
                        end else begin
                            n_blink_pre = blink_inc;
                        end
                    end
                end
                default: begin
                    // Key press: any key in a setting phase shows the digit again.
                    if (!r_phase[2]) begin
                        n_blink = 1'b0;
                        if (i_key == KEY_UP) begin
                            case (r_phase[1:0])
                                2'd0:    n_clk_hr  = 5'(fn_wrap_up({1'b0, r_clk_hr}, HOUR_TOP));
                                2'd1:    n_clk_min = fn_wrap_up(r_clk_min, MIN_TOP);
                                2'd2:    n_tmr_hr  = 5'(fn_wrap_up({1'b0, r_tmr_hr}, HOUR_TOP));
                                default: n_tmr_min = fn_wrap_up(r_tmr_min, MIN_TOP);
                            endcase
                        end else if (i_key == KEY_DOWN) begin
                            case (r_phase[1:0])
                                2'd0:    n_clk_hr  = 5'(fn_wrap_down({1'b0, r_clk_hr}, HOUR_TOP));
                                2'd1:    n_clk_min = fn_wrap_down(r_clk_min, MIN_TOP);
                                2'd2:    n_tmr_hr  = 5'(fn_wrap_down({1'b0, r_tmr_hr}, HOUR_TOP));
                                default: n_tmr_min = fn_wrap_down(r_tmr_min, MIN_TOP);
                            endcase
                        end
                    end
                    if (i_key == KEY_SWITCH) begin
                        unique case (r_phase)
                            PH_SET_CLK_HR: n_phase = PH_SET_CLK_MIN;
                            PH_SET_CLK_MIN: begin
                                n_phase = PH_SET_TMR_HR;
                                n_lamp  = 1'b0;
                            end
                            PH_SET_TMR_HR: n_phase = PH_SET_TMR_MIN;
                            PH_SET_TMR_MIN: begin
                                // A timer of zero is not started.
                                if (r_tmr_hr == 5'd0 && r_tmr_min == 6'd0) begin
                                    n_phase = PH_CLOCK;
                                end else begin
                                    n_tmr_sec = SEC_RELOAD;
                                    n_tmr_pre = '0;
                                    n_phase   = PH_TMR_RUN;
                                end
                            end
                            PH_CLOCK: begin
                                n_phase = PH_SET_TMR_HR;
                                n_lamp  = 1'b0;
                                n_blink = 1'b0;
                            end
                            PH_TMR_RUN: begin
                                n_tmr_hr  = '0;
                                n_tmr_min = '0;
                                n_phase   = PH_CLOCK;
                            end
                            default: n_phase = PH_CLOCK;
                        endcase
                    end
                end
            endcase
        end
    end

    assign o_view = '{
        phase:   r_phase,
        clk_hr:  r_clk_hr,
        clk_min: r_clk_min,
        tmr_hr:  r_tmr_hr,
        tmr_min: r_tmr_min,
        blink:   r_blink,
        lamp:    r_lamp
    };

endmodule

/* hdl/cwct_disp.sv */
// Display formatter: picks clock or timer, splits into BCD digits, sets flags.
`timescale 1ns / 1ps

module cwct_disp (
    input  cwct_pkg::t_view   i_view,
    output cwct_pkg::t_result o_result
);
    import cwct_pkg::*;

    logic       timer_shown;
    logic [4:0] hr;
    logic [5:0] mins;
    logic [1:0] hr_tens;
    logic [4:0] hr_rem;
    logic [2:0] min_tens;
    logic [5:0] min_rem;

    always_comb begin
        timer_shown = (i_view.phase == PH_SET_TMR_HR) || (i_view.phase == PH_SET_TMR_MIN) ||
                      (i_view.phase == PH_TMR_RUN) || (i_view.phase == PH_ALARM);
        hr   = timer_shown ? i_view.tmr_hr : i_view.clk_hr;
        mins = timer_shown ? i_view.tmr_min : i_view.clk_min;
        if (hr > 5'(HOUR_TOP)) begin
            hr = 5'(HOUR_TOP);
        end
        if (mins > MIN_TOP) begin
            mins = MIN_TOP;
        end

        // Digit split by comparison against the tens boundaries.
        if (hr >= 5'd20) begin
            hr_tens = 2'd2;
            hr_rem  = 5'(hr - 5'd20);
        end else if (hr >= 5'd10) begin
            hr_tens = 2'd1;
            hr_rem  = 5'(hr - 5'd10);
        end else begin
            hr_tens = 2'd0;
            hr_rem  = hr;
        end

        if (mins >= 6'd50) begin
            min_tens = 3'd5;
            min_rem  = 6'(mins - 6'd50);
        end else if (mins >= 6'd40) begin
            min_tens = 3'd4;
            min_rem  = 6'(mins - 6'd40);
        end else if (mins >= 6'd30) begin
            min_tens = 3'd3;
            min_rem  = 6'(mins - 6'd30);
        end else if (mins >= 6'd20) begin
            min_tens = 3'd2;
            min_rem  = 6'(mins - 6'd20);
        end else if (mins >= 6'd10) begin
            min_tens = 3'd1;
            min_rem  = 6'(mins - 6'd10);
        end else begin
            min_tens = 3'd0;
            min_rem  = mins;
        end

        o_result.hour_tens    = hr_tens;
        o_result.hour_units   = hr_rem[3:0];
        o_result.minute_tens  = min_tens;
        o_result.minute_units = min_rem[3:0];
        o_result.hour_tens_blank = i_view.blink &&
            ((i_view.phase == PH_SET_CLK_HR) || (i_view.phase == PH_SET_TMR_HR));
        o_result.minute_tens_blank = i_view.blink &&
            ((i_view.phase == PH_SET_CLK_MIN) || (i_view.phase == PH_SET_TMR_MIN));
        if (i_view.phase == PH_TMR_RUN) begin
            o_result.lamp_on = 1'b1;
        end else if ((i_view.phase == PH_SET_TMR_HR) || (i_view.phase == PH_SET_TMR_MIN)) begin
            o_result.lamp_on = i_view.lamp;
        end else begin
            o_result.lamp_on = 1'b0;
        end
        o_result.alarm_on  = (i_view.phase == PH_ALARM);
        o_result.phase_now = i_view.phase;
    end

endmodule

/* hdl/clock_with_countdown_timer.sv */
// Top level: stream ports, configuration registers, input and result registers.
// A beat in the input register fires once the result side can advance; the state
// registers and the pending flag are loaded together, and its result is then
// offered on m_axis straight from the formatter.
// Throughput: one beat per cycle while m_axis accepts results; the only loop is
// the state update from the input register.
// Reset (synchronous, active low): set clock hour phase, clock 00:00:00,
// timer 00:00, all dividers 1, pipeline empty.
`timescale 1ns / 1ps

module clock_with_countdown_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] key_code, [7:4] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [1:0] hour_tens, [5:2] hour_units,
                                        // [8:6] minute_tens, [12:9] minute_units,
                                        // [13] hour_tens_blank, [14] minute_tens_blank,
                                        // [15] lamp_on, [16] alarm_on, [19:17] phase_now,
                                        // [23:20] zero
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import cwct_pkg::*;

    // Configuration registers. Writes to an index beyond the list are dropped.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clk_div   <= 16'd1;
            r_cfg.tmr_div   <= 16'd1;
            r_cfg.blink_div <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLK_DIV:   r_cfg.clk_div   <= i_cfg_data;
                CFG_TMR_DIV:   r_cfg.tmr_div   <= i_cfg_data;
                CFG_BLINK_DIV: r_cfg.blink_div <= i_cfg_data;
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    // The input register holds one beat; it moves on whenever the result
    // register is empty or being emptied, so a waiting result holds the input
    // off only once the input register is full as well.
    logic       r_in_valid;
    t_mode      r_mode;
    logic [3:0] r_key;
    logic       advance;
    logic       fire;

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_mode <= t_mode'(s_axis_tuser);
            r_key  <= s_axis_tdata[3:0];
        end
    end

    // State update: the beat in the input register is applied when it fires.
    t_view   view_next;
    t_view   view_now;
    t_result result;

    cwct_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_mode  (r_mode),
        .i_key   (r_key),
        .i_cfg   (r_cfg),
        .o_view  (view_now)
    );

    // The result shows the state after the beat, so the display is formed
    // from the registered state after the update; the result register is
    // loaded from the state that the fired beat left behind.
    assign view_next = view_now;

    cwct_disp u_disp (
        .i_view   (view_next),
        .o_result (result)
    );

    // Result register. It is loaded in the cycle after a beat fires, when the
    // state registers already hold that beat's outcome. If the result is taken
    // in that same cycle there is nothing left to hold.
    logic    r_pend;
    logic    r_out_valid;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend) begin
            r_out_valid <= !m_axis_tready;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_out <= result;
        end
    end

    // While a load is pending the fresh result is offered straight from the
    // formatter; the result register keeps it only when that offer is not taken.
    assign m_axis_tvalid = r_out_valid || r_pend;
    assign m_axis_tdata  = {4'd0, (r_pend ? result : r_out)};

`ifndef SYNTHESIS
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> m_axis_tvalid)
        else $error("fired beat produced no result");

    a_clock_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (view_now.clk_hr <= 5'd23) && (view_now.clk_min <= 6'd59))
        else $error("clock fields out of range");

    a_ready_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    a_alarm_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(view_now.phase == PH_ALARM)) |-> ($past(view_now.phase) == PH_TMR_RUN))
        else $error("alarm entered from a phase other than timer running");
`endif

endmodule
